/* rtl/obb_pkg.sv */
// obb_pkg: widths, codes and control store for the 2d oriented box overlap tester
// no dependencies; imported by obb_overlap_test_2d_top, obb_chk and tb_obb_overlap_test_2d_top
package obb_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int CW_EFF      = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;

    localparam int CTR_W   = 32;
    localparam int AXIS_W  = 18;
    localparam int HALF_W  = 31;
    localparam int FRAC_W  = 16;
    localparam int HALF_SH = 32;

    localparam int DIFF_W = CW_EFF + 1;
    localparam int T_W    = 2 * AXIS_W + 1;
    localparam int A_W    = (DIFF_W > T_W + 1) ? DIFF_W : T_W + 1;
    localparam int B_W    = HALF_W + 1;
    localparam int PROD_W = A_W + B_W;
    localparam int ACC_W  = PROD_W + 1;
    localparam int RHS_W  = PROD_W + 2;
    localparam int CMP_W  = ACC_W + FRAC_W;

    localparam int UC_LEN = 33;
    localparam int STEP_W = $clog2(UC_LEN);

    localparam logic ACT_STORE = 1'b0;
    localparam logic ACT_TEST  = 1'b1;

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} t_state;

    typedef enum logic [2:0] {A_DX, A_DY, A_O0, A_O1, A_O2, A_O3, A_T} t_asel;
    typedef enum logic [1:0] {B_AX, B_AY, B_OH0, B_OH1} t_bsel;
    typedef enum logic [2:0] {P_NOP, P_ACC_LD, P_T_ABS, P_RHS_LD, P_RHS_ADD, P_CMP} t_post;
    typedef enum logic [1:0] {J_NEXT, J_SEP_DONE, J_DONE} t_jump;

    typedef struct packed {
        t_asel      a_sel;
        t_bsel      b_sel;
        t_post      post;
        t_jump      jump;
        logic [1:0] axis;
    } t_uc;

    // control store: eight steps per axis, then one step to finish the last compare
    function automatic t_uc uc_rom(input logic [STEP_W-1:0] step);
        t_uc        w;
        logic [1:0] ax;
        ax     = step[4:3];
        w.a_sel = A_DX;
        w.b_sel = B_AX;
        w.post  = P_NOP;
        w.jump  = J_NEXT;
        w.axis  = ax;
        if (step == STEP_W'(UC_LEN - 1)) begin
            w.post = P_CMP;
            w.jump = J_DONE;
            w.axis = 2'd3;
        end else begin
            unique case (step[2:0])
                3'd0: begin
                    w.a_sel = A_O0;
                    w.b_sel = B_AX;
                    w.post  = (ax == 2'd0) ? P_NOP : P_CMP;
                    w.jump  = (ax == 2'd0) ? J_NEXT : J_SEP_DONE;
                end
                3'd1: begin
                    w.a_sel = A_O1;
                    w.b_sel = B_AY;
                    w.post  = P_ACC_LD;
                end
                3'd2: begin
                    w.a_sel = A_O2;
                    w.b_sel = B_AX;
                    w.post  = P_T_ABS;
                end
                3'd3: begin
                    w.a_sel = A_T;
                    w.b_sel = B_OH0;
                    w.post  = P_ACC_LD;
                end
                3'd4: begin
                    w.a_sel = A_O3;
                    w.b_sel = B_AY;
                    w.post  = P_RHS_LD;
                end
                3'd5: begin
                    w.a_sel = A_DX;
                    w.b_sel = B_AX;
                    w.post  = P_T_ABS;
                end
                3'd6: begin
                    w.a_sel = A_T;
                    w.b_sel = B_OH1;
                    w.post  = P_ACC_LD;
                end
                3'd7: begin
                    w.a_sel = A_DY;
                    w.b_sel = B_AY;
                    w.post  = P_RHS_ADD;
                end
            endcase
        end
        return w;
    endfunction

endpackage

/* rtl/obb_overlap_test_2d_top.sv */
// obb_overlap_test_2d_top: separating-axis overlap test of two oriented 2d boxes
// microcoded sequencer around one shared multiplier; depends on obb_pkg
//
// channel   direction  handshake                 payload
// in        input      i_in_valid / o_in_ready   i_action, i_center_*, i_axis_*, i_half_*
// out       output     o_out_valid / i_out_ready o_overlap
//
// a store word gives no result
// a test word runs 9 to 33 sequencer steps (8 per axis plus one, stopping after the
// first separating axis found), all on the single multiplier, then posts the result
// from the done state once the output register is empty or being taken
// input is taken only while the sequencer is idle; a waiting result does not block it
// synchronous active-low reset clears the reference box to zero
module obb_overlap_test_2d_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_action,
    input  logic signed [obb_pkg::CTR_W-1:0]    i_center_x,
    input  logic signed [obb_pkg::CTR_W-1:0]    i_center_y,
    input  logic signed [obb_pkg::AXIS_W-1:0]   i_axis_u_x,
    input  logic signed [obb_pkg::AXIS_W-1:0]   i_axis_u_y,
    input  logic signed [obb_pkg::AXIS_W-1:0]   i_axis_v_x,
    input  logic signed [obb_pkg::AXIS_W-1:0]   i_axis_v_y,
    input  logic        [obb_pkg::HALF_W-1:0]   i_half_u,
    input  logic        [obb_pkg::HALF_W-1:0]   i_half_v,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_overlap
);
    import obb_pkg::*;

    t_state                     r_state, n_state;
    logic [STEP_W-1:0]          r_step, n_step;
    logic                       r_sep, n_sep;
    logic                       r_out_valid, n_out_valid;
    logic                       r_overlap, n_overlap;

    logic signed [CTR_W-1:0]    r_ref_cx, r_ref_cy, r_tst_cx, r_tst_cy;
    logic signed [AXIS_W-1:0]   r_ref_ux, r_ref_uy, r_ref_vx, r_ref_vy;
    logic signed [AXIS_W-1:0]   r_tst_ux, r_tst_uy, r_tst_vx, r_tst_vy;
    logic [HALF_W-1:0]          r_ref_hu, r_ref_hv, r_tst_hu, r_tst_hv;

    logic signed [PROD_W-1:0]   r_prod, n_prod;
    logic signed [ACC_W-1:0]    r_acc, n_acc;
    logic [T_W-1:0]             r_t, n_t;
    logic [RHS_W-1:0]           r_rhs, n_rhs;

    t_uc                        uc;
    logic                       in_acc;
    logic signed [AXIS_W-1:0]   own_x, own_y, oth0, oth1, oth2, oth3;
    logic [HALF_W-1:0]          own_h, oth_h0, oth_h1;
    logic signed [A_W-1:0]      dx, dy, a_op;
    logic signed [B_W-1:0]      b_op;
    logic signed [ACC_W-1:0]    sum;
    logic [ACC_W-1:0]           abs_sum;
    logic [CMP_W-1:0]           lhs;
    logic                       cmp_gt, sep_now;

    assign in_acc      = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_overlap   = r_overlap;
    assign uc          = uc_rom(r_step);

    // centre differences, truncated to the effective coordinate width
    assign dx = A_W'($signed(r_ref_cx[CW_EFF-1:0])) - A_W'($signed(r_tst_cx[CW_EFF-1:0]));
    assign dy = A_W'($signed(r_ref_cy[CW_EFF-1:0])) - A_W'($signed(r_tst_cy[CW_EFF-1:0]));

    always_comb begin
        unique case (uc.axis)
            2'd0: begin
                own_x = r_ref_ux;
                own_y = r_ref_uy;
                own_h = r_ref_hu;
            end
            2'd1: begin
                own_x = r_ref_vx;
                own_y = r_ref_vy;
                own_h = r_ref_hv;
            end
            2'd2: begin
                own_x = r_tst_ux;
                own_y = r_tst_uy;
                own_h = r_tst_hu;
            end
            default: begin
                own_x = r_tst_vx;
                own_y = r_tst_vy;
                own_h = r_tst_hv;
            end
        endcase
        if (uc.axis[1] == 1'b0) begin
            oth0   = r_tst_ux;
            oth1   = r_tst_uy;
            oth2   = r_tst_vx;
            oth3   = r_tst_vy;
            oth_h0 = r_tst_hu;
            oth_h1 = r_tst_hv;
        end else begin
            oth0   = r_ref_ux;
            oth1   = r_ref_uy;
            oth2   = r_ref_vx;
            oth3   = r_ref_vy;
            oth_h0 = r_ref_hu;
            oth_h1 = r_ref_hv;
        end
    end

    always_comb begin
        unique case (uc.a_sel)
            A_DX:    a_op = dx;
            A_DY:    a_op = dy;
            A_O0:    a_op = A_W'(oth0);
            A_O1:    a_op = A_W'(oth1);
            A_O2:    a_op = A_W'(oth2);
            A_O3:    a_op = A_W'(oth3);
            A_T:     a_op = $signed(A_W'(r_t));
            default: a_op = '0;
        endcase
        unique case (uc.b_sel)
            B_AX:    b_op = B_W'(own_x);
            B_AY:    b_op = B_W'(own_y);
            B_OH0:   b_op = $signed(B_W'(oth_h0));
            default: b_op = $signed(B_W'(oth_h1));
        endcase
    end

    // post operations act on the product issued by the previous step
    always_comb begin
        sum     = r_acc + ACC_W'(r_prod);
        abs_sum = sum[ACC_W-1] ? ACC_W'(-sum) : ACC_W'(sum);
        lhs     = {abs_sum, {FRAC_W{1'b0}}};
        cmp_gt  = lhs > CMP_W'(r_rhs);
        sep_now = r_sep || ((uc.post == P_CMP) && cmp_gt);

        n_prod = a_op * b_op;
        n_acc  = r_acc;
        n_t    = r_t;
        n_rhs  = r_rhs;
        unique case (uc.post)
            P_ACC_LD:  n_acc = ACC_W'(r_prod);
            P_T_ABS:   n_t   = abs_sum[T_W-1:0];
            P_RHS_LD:  n_rhs = RHS_W'({own_h, {HALF_SH{1'b0}}})
                               + RHS_W'($unsigned(r_prod));
            P_RHS_ADD: n_rhs = r_rhs + RHS_W'($unsigned(r_prod));
            default:   n_rhs = r_rhs;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_sep       = r_sep;
        n_out_valid = r_out_valid && !i_out_ready;
        n_overlap   = r_overlap;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && (i_action == ACT_TEST)) begin
                    n_state = ST_RUN;
                    n_step  = '0;
                    n_sep   = 1'b0;
                end
            end
            ST_RUN: begin
                n_sep = sep_now;
                if ((uc.jump == J_DONE) || ((uc.jump == J_SEP_DONE) && sep_now)) begin
                    n_state = ST_DONE;
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_overlap   = !r_sep;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= '0;
            r_sep       <= 1'b0;
            r_out_valid <= 1'b0;
            r_ref_cx    <= '0;
            r_ref_cy    <= '0;
            r_ref_ux    <= '0;
            r_ref_uy    <= '0;
            r_ref_vx    <= '0;
            r_ref_vy    <= '0;
            r_ref_hu    <= '0;
            r_ref_hv    <= '0;
        end else begin
            r_step      <= n_step;
            r_sep       <= n_sep;
            r_out_valid <= n_out_valid;
            if (in_acc && (i_action == ACT_STORE)) begin
                r_ref_cx <= i_center_x;
                r_ref_cy <= i_center_y;
                r_ref_ux <= i_axis_u_x;
                r_ref_uy <= i_axis_u_y;
                r_ref_vx <= i_axis_v_x;
                r_ref_vy <= i_axis_v_y;
                r_ref_hu <= i_half_u;
                r_ref_hv <= i_half_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_overlap <= n_overlap;
        if (in_acc && (i_action == ACT_TEST)) begin
            r_tst_cx <= i_center_x;
            r_tst_cy <= i_center_y;
            r_tst_ux <= i_axis_u_x;
            r_tst_uy <= i_axis_u_y;
            r_tst_vx <= i_axis_v_x;
            r_tst_vy <= i_axis_v_y;
            r_tst_hu <= i_half_u;
            r_tst_hv <= i_half_v;
        end
        if (r_state == ST_RUN) begin
            r_prod <= n_prod;
            r_acc  <= n_acc;
            r_t    <= n_t;
            r_rhs  <= n_rhs;
        end
    end

endmodule

/* rtl/obb_chk.sv */
// obb_chk: port-level checks for obb_overlap_test_2d_top, attached by bind
// depends on obb_pkg for the action codes
module obb_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input logic i_action,
    input logic o_out_valid,
    input logic i_out_ready,
    input logic o_overlap
);
    import obb_pkg::*;

    logic in_acc;
    assign in_acc = i_in_valid && o_in_ready;

    // no result word comes out of reset
    a_rst_clear: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_overlap)))
        else $error("stalled result word changed");

    // a store word produces no result
    a_store_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_action == ACT_STORE) && !o_out_valid) |=> !o_out_valid)
        else $error("store word produced a result");

    // a test word keeps the input closed while it runs
    a_test_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_action == ACT_TEST)) |=> !o_in_ready)
        else $error("input open during a test");

    // a result is only posted from the busy side
    a_post_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result posted while idle");

endmodule

bind obb_overlap_test_2d_top obb_chk u_obb_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_action    (i_action),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_overlap   (o_overlap)
);

/* test/tb_obb_overlap_test_2d_top.sv */
// tb_obb_overlap_test_2d_top: self-checking bench for the 2d oriented box overlap tester
// walks a directed table, then random store/test words under varied idling on both channels
// depends on obb_pkg and obb_overlap_test_2d_top
module tb_obb_overlap_test_2d_top;
    timeunit 1ns;
    timeprecision 1ps;
    import obb_pkg::*;

    localparam int NO_PIN     = -1;
    localparam int IDLE_LIMIT = 3000;
    localparam int LONG_HOLD  = 300;

    localparam logic [CTR_W-1:0]  Q_ONE       = 32'h0001_0000;
    localparam logic [CTR_W-1:0]  CTR_MAX     = 32'h7FFF_FFFF;
    localparam logic [CTR_W-1:0]  CTR_MIN     = 32'h8000_0000;
    localparam logic [AXIS_W-1:0] AX_ONE      = 18'h10000;
    localparam logic [AXIS_W-1:0] AX_NEG_ONE  = 18'h30000;
    localparam logic [AXIS_W-1:0] AX_MAX      = 18'h1FFFF;
    localparam logic [AXIS_W-1:0] AX_MIN      = 18'h20000;
    localparam logic [AXIS_W-1:0] AX_DIAG     = 18'd46341;
    localparam logic [HALF_W-1:0] HALF_ONE    = 31'h0001_0000;
    localparam logic [HALF_W-1:0] HALF_MAX    = 31'h7FFF_FFFF;

    typedef struct packed {
        logic              act;
        logic [CTR_W-1:0]  cx;
        logic [CTR_W-1:0]  cy;
        logic [AXIS_W-1:0] ux;
        logic [AXIS_W-1:0] uy;
        logic [AXIS_W-1:0] vx;
        logic [AXIS_W-1:0] vy;
        logic [HALF_W-1:0] hu;
        logic [HALF_W-1:0] hv;
    } t_box_word;

    typedef struct {
        t_box_word w;
        int        overlap;
    } t_dir_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic               i_action;
    logic [CTR_W-1:0]   i_center_x;
    logic [CTR_W-1:0]   i_center_y;
    logic [AXIS_W-1:0]  i_axis_u_x;
    logic [AXIS_W-1:0]  i_axis_u_y;
    logic [AXIS_W-1:0]  i_axis_v_x;
    logic [AXIS_W-1:0]  i_axis_v_y;
    logic [HALF_W-1:0]  i_half_u;
    logic [HALF_W-1:0]  i_half_v;
    logic               o_out_valid;
    logic               i_out_ready;
    logic               o_overlap;

    t_box_word held_box = '0;
    bit        overlap_due[$];
    int        pinned_overlap;
    int        mismatches = 0;
    int        send_idle;
    int        recv_stall;
    int        hold_req;
    int        quiet_cycles = 0;

    t_dir_row dir_rows [0:17] = '{
        '{'{ACT_TEST,  32'h0, 32'h0, AX_ONE, 18'h0, 18'h0, AX_ONE, 31'h0, 31'h0}, 1},
        '{'{ACT_TEST,  Q_ONE, 32'h0, AX_ONE, 18'h0, 18'h0, AX_ONE, 31'h0, 31'h0}, 0},
        '{'{ACT_TEST,  CTR_MAX, CTR_MIN, 18'h0, 18'h0, 18'h0, 18'h0, 31'h0, 31'h0}, 1},
        '{'{ACT_STORE, 32'h0, 32'h0, AX_ONE, 18'h0, 18'h0, AX_ONE, HALF_ONE, HALF_ONE},
          NO_PIN},
        '{'{ACT_TEST,  32'h0002_0000, 32'h0, AX_ONE, 18'h0, 18'h0, AX_ONE,
            HALF_ONE, HALF_ONE}, NO_PIN},
        '{'{ACT_TEST,  32'h0002_0001, 32'h0, AX_ONE, 18'h0, 18'h0, AX_ONE,
            HALF_ONE, HALF_ONE}, NO_PIN},
        '{'{ACT_TEST,  Q_ONE, 32'h0000_8000, AX_DIAG, AX_DIAG, 18'h3_4B4B, AX_DIAG,
            HALF_ONE, 31'h0000_4000}, NO_PIN},
        '{'{ACT_TEST,  32'hFFFD_0000, 32'h0002_8000, AX_NEG_ONE, 18'h0, 18'h0, AX_NEG_ONE,
            31'h0001_8000, 31'h0000_8000}, NO_PIN},
        '{'{ACT_STORE, CTR_MAX, CTR_MIN, AX_MAX, AX_MIN, AX_MIN, AX_MAX, HALF_MAX, HALF_MAX},
          NO_PIN},
        '{'{ACT_TEST,  CTR_MIN, CTR_MAX, AX_MIN, AX_MAX, AX_MAX, AX_MIN, HALF_MAX, HALF_MAX},
          NO_PIN},
        '{'{ACT_TEST,  CTR_MIN, CTR_MAX, AX_MAX, AX_MAX, AX_MIN, AX_MIN, 31'h0, 31'h0},
          NO_PIN},
        '{'{ACT_TEST,  32'h0, 32'h0, 18'h0, 18'h0, 18'h0, 18'h0, 31'h0, 31'h0}, NO_PIN},
        '{'{ACT_STORE, 32'hFFFF_0000, Q_ONE, AX_MAX, 18'd3, 18'd3, AX_MIN, 31'h0, 31'h0},
          NO_PIN},
        '{'{ACT_TEST,  Q_ONE, 32'hFFFF_0000, AX_ONE, AX_ONE, AX_NEG_ONE, AX_ONE,
            31'h0000_C000, HALF_MAX}, NO_PIN},
        '{'{ACT_STORE, CTR_MAX, CTR_MAX, 18'h0, 18'h0, 18'h0, 18'h0, 31'h0, 31'h0}, NO_PIN},
        '{'{ACT_TEST,  CTR_MIN, CTR_MIN, 18'h0, 18'h0, 18'h0, 18'h0, 31'h0, 31'h0}, 1},
        '{'{ACT_TEST,  CTR_MIN, CTR_MIN, AX_ONE, 18'h0, 18'h0, AX_ONE, HALF_MAX, HALF_MAX},
          NO_PIN},
        '{'{ACT_STORE, 32'h0, 32'h0, AX_ONE, 18'h0, 18'h0, AX_ONE, HALF_ONE, HALF_ONE},
          NO_PIN}
    };

    obb_overlap_test_2d_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_action    (i_action),
        .i_center_x  (i_center_x),
        .i_center_y  (i_center_y),
        .i_axis_u_x  (i_axis_u_x),
        .i_axis_u_y  (i_axis_u_y),
        .i_axis_v_x  (i_axis_v_x),
        .i_axis_v_y  (i_axis_v_y),
        .i_half_u    (i_half_u),
        .i_half_v    (i_half_v),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_overlap   (o_overlap)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    function automatic longint ctr_ext(input logic [CTR_W-1:0] v);
        logic signed [63:0] t;
        t = 64'(v) << (64 - CW_EFF);
        return longint'(t >>> (64 - CW_EFF));
    endfunction

    function automatic longint axis_ext(input logic [AXIS_W-1:0] v);
        return longint'(signed'(v));
    endfunction

    function automatic logic [127:0] proj_mag(input longint ax, input longint ay,
                                              input longint bx, input longint by);
        longint p;
        p = ax * bx + ay * by;
        return (p < 0) ? 128'(-p) : 128'(p);
    endfunction

    // true if axis (ax, ay), owned by the box with half length own_half, splits the pair
    function automatic bit axis_splits(input longint dx, input longint dy,
                                       input longint ax, input longint ay,
                                       input logic [HALF_W-1:0] own_half,
                                       input longint oth [4],
                                       input logic [HALF_W-1:0] oth_h0,
                                       input logic [HALF_W-1:0] oth_h1);
        logic [127:0] lhs;
        logic [127:0] rhs;
        lhs = proj_mag(dx, dy, ax, ay) << 16;
        rhs = (128'(own_half) << 32)
            + proj_mag(oth[0], oth[1], ax, ay) * 128'(oth_h0)
            + proj_mag(oth[2], oth[3], ax, ay) * 128'(oth_h1);
        return lhs > rhs;
    endfunction

    function automatic bit boxes_overlap(input t_box_word r, input t_box_word t);
        longint ra [4];
        longint ta [4];
        longint dx;
        longint dy;
        ra = '{axis_ext(r.ux), axis_ext(r.uy), axis_ext(r.vx), axis_ext(r.vy)};
        ta = '{axis_ext(t.ux), axis_ext(t.uy), axis_ext(t.vx), axis_ext(t.vy)};
        dx = ctr_ext(r.cx) - ctr_ext(t.cx);
        dy = ctr_ext(r.cy) - ctr_ext(t.cy);
        return !(axis_splits(dx, dy, ra[0], ra[1], r.hu, ta, t.hu, t.hv) ||
                 axis_splits(dx, dy, ra[2], ra[3], r.hv, ta, t.hu, t.hv) ||
                 axis_splits(dx, dy, ta[0], ta[1], t.hu, ra, r.hu, r.hv) ||
                 axis_splits(dx, dy, ta[2], ta[3], t.hv, ra, r.hu, r.hv));
    endfunction

    function automatic logic [AXIS_W-1:0] rand_axis();
        int pick;
        pick = $urandom_range(99);
        if (pick < 15) begin
            case ($urandom_range(4))
                0: return AX_MAX;
                1: return AX_MIN;
                2: return AX_ONE;
                3: return AX_NEG_ONE;
                default: return '0;
            endcase
        end
        if (pick < 40) return AXIS_W'($urandom);
        return AXIS_W'($urandom_range(131072) - 65536);
    endfunction

    function automatic logic [HALF_W-1:0] rand_half();
        int pick;
        pick = $urandom_range(99);
        if (pick < 60) return HALF_W'($urandom_range(196608));
        if (pick < 85) return HALF_W'($urandom);
        return ($urandom_range(1) != 0) ? HALF_MAX : '0;
    endfunction

    function automatic logic [CTR_W-1:0] rand_ctr();
        if ($urandom_range(99) < 65) return CTR_W'($urandom_range(524288) - 262144);
        return $urandom;
    endfunction

    function automatic t_box_word rand_box(input bit test_only);
        t_box_word w;
        w.act = (!test_only && $urandom_range(99) < 20) ? ACT_STORE : ACT_TEST;
        w.cx  = rand_ctr();
        w.cy  = rand_ctr();
        w.ux  = rand_axis();
        w.uy  = rand_axis();
        w.vx  = rand_axis();
        w.vy  = rand_axis();
        w.hu  = rand_half();
        w.hv  = rand_half();
        return w;
    endfunction

    task automatic offer(input t_box_word w);
        while ($urandom_range(99) < send_idle) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_action   = w.act;
        i_center_x = w.cx;
        i_center_y = w.cy;
        i_axis_u_x = w.ux;
        i_axis_u_y = w.uy;
        i_axis_v_x = w.vx;
        i_axis_v_y = w.vy;
        i_half_u   = w.hu;
        i_half_v   = w.hv;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    task automatic drain();
        while (overlap_due.size() != 0) @(posedge i_clk);
    endtask

    // scoreboard: check the leaving word, then predict from the accepted one
    always @(posedge i_clk) begin
        t_box_word acc;
        bit        want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (overlap_due.size() == 0) begin
                    $error("overlap: no result expected, got %0d", o_overlap);
                    mismatches++;
                end else begin
                    want = overlap_due.pop_front();
                    if (o_overlap !== want) begin
                        $error("overlap: expected %0d, got %0d", want, o_overlap);
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                acc = '{i_action, i_center_x, i_center_y, i_axis_u_x, i_axis_u_y,
                        i_axis_v_x, i_axis_v_y, i_half_u, i_half_v};
                if (acc.act == ACT_STORE) begin
                    held_box = acc;
                end else if (pinned_overlap != NO_PIN) begin
                    overlap_due.push_back(pinned_overlap[0]);
                end else begin
                    overlap_due.push_back(boxes_overlap(held_box, acc));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int hold_left;
        bit hold_taken;
        hold_left   = 0;
        hold_taken  = 1'b0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if ((hold_req != 0) && !hold_taken) begin
                hold_left  = hold_req;
                hold_taken = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready = 1'b0;
            end else begin
                i_out_ready = ($urandom_range(99) >= recv_stall);
            end
        end
    end

    initial begin
        int idle_plan [4][2];
        idle_plan      = '{'{0, 0}, '{75, 0}, '{0, 75}, '{27, 27}};
        pinned_overlap = NO_PIN;
        send_idle      = 0;
        recv_stall     = 0;
        hold_req       = 0;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_action       = ACT_STORE;
        i_center_x     = '0;
        i_center_y     = '0;
        i_axis_u_x     = '0;
        i_axis_u_y     = '0;
        i_axis_v_x     = '0;
        i_axis_v_y     = '0;
        i_half_u       = '0;
        i_half_v       = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[i]) begin
            pinned_overlap = dir_rows[i].overlap;
            offer(dir_rows[i].w);
        end
        pinned_overlap = NO_PIN;

        for (int ph = 0; ph < 4; ph++) begin
            send_idle  = idle_plan[ph][0];
            recv_stall = idle_plan[ph][1];
            repeat (110) offer(rand_box(1'b0));
        end

        // long receiver hold-off with words coming, a full pause, then more stalled words
        send_idle  = 0;
        recv_stall = 0;
        hold_req   = LONG_HOLD;
        repeat (12) offer(rand_box(1'b1));
        i_in_valid = 1'b0;
        drain();
        @(negedge i_clk);
        recv_stall = 27;
        repeat (20) offer(rand_box(1'b0));
        i_in_valid = 1'b0;

        drain();
        repeat (40) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/obb_pkg.sv
rtl/obb_overlap_test_2d_top.sv
rtl/obb_chk.sv
test/tb_obb_overlap_test_2d_top.sv
